// File: rtl/teq_pkg.sv
package teq_pkg;

   localparam int unsigned DefCapacity    = 32;
   localparam int unsigned DefHandlerBits = 8;
   localparam int unsigned TimeW          = 32;
   localparam int unsigned ArgW           = 16;
   localparam int unsigned HidPortW       = 8;
   localparam logic [TimeW-1:0] AllOnes   = '1;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_RUN = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NOT_DUE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_REQUEUE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       start;
      logic       ins_new;
      logic       pop;
      logic       ins_pend;
      logic       load_rsp;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic head_due;
      logic head_cyclic;
      logic out_free;
   } stat_type;

endpackage

// File: rtl/teq_ctrl.sv
module teq_ctrl
   import teq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_operation,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   op_type    op;

   assign op = op_type'(req_operation);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (op == OP_RUN && stat.head_due && stat.head_cyclic) begin
                  state_in = S_REQUEUE;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_REQUEUE: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               if (op == OP_ADD) begin
                  if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.status  = ST_OK;
                     cmd.ins_new = 1'b1;
                  end
               end else begin
                  if (stat.head_due) begin
                     cmd.status = ST_OK;
                     cmd.pop    = 1'b1;
                  end else begin
                     cmd.status = ST_NOT_DUE;
                  end
               end
            end
         end
         S_REQUEUE: begin
            cmd.ins_pend = 1'b1;
         end
         S_DONE: begin
            cmd.load_rsp = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: rtl/teq_dpath.sv
module teq_dpath
   import teq_pkg::*;
#(
   parameter int unsigned Capacity    = DefCapacity,
   parameter int unsigned HandlerBits = DefHandlerBits,
   localparam int unsigned CntW       = $clog2(Capacity + 1)
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [TimeW-1:0]    req_now_time,
   input  logic [HidPortW-1:0] req_handler_id,
   input  logic [ArgW-1:0]     req_handler_arg,
   input  logic [TimeW-1:0]    req_delay_ticks,
   input  logic                req_repeating,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic                rsp_fired,
   output logic [HidPortW-1:0] rsp_fired_handler,
   output logic [ArgW-1:0]     rsp_fired_arg,
   output logic [TimeW-1:0]    rsp_earliest_due,
   output logic [CntW-1:0]     rsp_occupancy
);

   localparam int unsigned HidW = (HandlerBits < HidPortW) ? HandlerBits : HidPortW;

   logic [TimeW-1:0] due_ff [Capacity];
   logic [TimeW-1:0] iv_ff  [Capacity];
   logic [HidW-1:0]  hid_ff [Capacity];
   logic [ArgW-1:0]  arg_ff [Capacity];

   logic [CntW-1:0]  count_ff, count_in;
   logic [TimeW-1:0] pend_due_ff, pend_iv_ff;
   logic [HidW-1:0]  pend_hid_ff;
   logic [ArgW-1:0]  pend_arg_ff;
   status_type       status_ff;
   logic             fired_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   logic             rsp_fired_ff;
   logic [HidW-1:0]  rsp_hid_ff;
   logic [ArgW-1:0]  rsp_arg_ff;
   logic [TimeW-1:0] rsp_due_ff;
   logic [CntW-1:0]  rsp_occ_ff;

   logic             ins;
   logic [TimeW-1:0] ins_due, ins_iv;
   logic [HidW-1:0]  ins_hid;
   logic [ArgW-1:0]  ins_arg;
   logic [Capacity-1:0] le;

   assign ins = cmd.ins_new | cmd.ins_pend;

   always_comb begin
      if (cmd.ins_pend) begin
         ins_due = pend_due_ff;
         ins_iv  = pend_iv_ff;
         ins_hid = pend_hid_ff;
         ins_arg = pend_arg_ff;
      end else begin
         ins_due = req_now_time + req_delay_ticks;
         ins_iv  = req_repeating ? req_delay_ticks : '0;
         ins_hid = HidW'(req_handler_id);
         ins_arg = req_handler_arg;
      end
   end

   for (genvar i = 0; i < Capacity; i++) begin : g_cell
      assign le[i] = (CntW'(i) < count_ff) && (due_ff[i] <= ins_due);

      if (i == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (cmd.pop) begin
               due_ff[i] <= due_ff[i+1];
               iv_ff[i]  <= iv_ff[i+1];
               hid_ff[i] <= hid_ff[i+1];
               arg_ff[i] <= arg_ff[i+1];
            end else if (ins && !le[i]) begin
               due_ff[i] <= ins_due;
               iv_ff[i]  <= ins_iv;
               hid_ff[i] <= ins_hid;
               arg_ff[i] <= ins_arg;
            end
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (cmd.pop) begin
               if (i < Capacity - 1) begin
                  due_ff[i] <= due_ff[(i+1) % Capacity];
                  iv_ff[i]  <= iv_ff[(i+1) % Capacity];
                  hid_ff[i] <= hid_ff[(i+1) % Capacity];
                  arg_ff[i] <= arg_ff[(i+1) % Capacity];
               end
            end else if (ins && !le[i]) begin
               if (le[i-1]) begin
                  due_ff[i] <= ins_due;
                  iv_ff[i]  <= ins_iv;
                  hid_ff[i] <= ins_hid;
                  arg_ff[i] <= ins_arg;
               end else begin
                  due_ff[i] <= due_ff[i-1];
                  iv_ff[i]  <= iv_ff[i-1];
                  hid_ff[i] <= hid_ff[i-1];
                  arg_ff[i] <= arg_ff[i-1];
               end
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end else if (ins) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         fired_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.start) begin
            fired_ff <= cmd.pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         status_ff <= cmd.status;
      end
      if (cmd.pop) begin
         pend_due_ff <= due_ff[0] + iv_ff[0];
         pend_iv_ff  <= iv_ff[0];
         pend_hid_ff <= hid_ff[0];
         pend_arg_ff <= arg_ff[0];
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_fired_ff  <= fired_ff;
         rsp_hid_ff    <= fired_ff ? pend_hid_ff : '0;
         rsp_arg_ff    <= fired_ff ? pend_arg_ff : '0;
         rsp_due_ff    <= (count_ff != '0) ? due_ff[0] : AllOnes;
         rsp_occ_ff    <= count_ff;
      end
   end

   assign stat.full        = (count_ff == CntW'(Capacity));
   assign stat.head_due    = (count_ff != '0) && (due_ff[0] <= req_now_time);
   assign stat.head_cyclic = (iv_ff[0] != '0);
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_fired_handler = HidPortW'(rsp_hid_ff);
   assign rsp_fired_arg     = rsp_arg_ff;
   assign rsp_earliest_due  = rsp_due_ff;
   assign rsp_occupancy     = rsp_occ_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Capacity))
      else $error("queue count above capacity");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CntW'(2) |-> due_ff[0] <= due_ff[1])
      else $error("queue head out of order");

   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fired_ff |-> rsp_status_ff == ST_OK)
      else $error("fired item without ok status");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> count_ff != '0)
      else $error("pop on empty queue");
`endif

endmodule

// File: rtl/timed_event_queue_core.sv
// Deadline-ordered event queue held in a row of shift-insert cells. An add
// inserts at now + delay behind every event with an equal or earlier due time;
// a run fires the head when its due time is at or before now, then requeues a
// repeating head at its old due time plus its interval. One item is worked on
// at a time: an add or non-repeating run goes from idle to the done state,
// where its result enters the output register once that register is free; a
// repeating run first passes a requeue state for a second pass through the
// cell row. The next item is taken once the result has moved into the output
// register, which holds it while the consumer stalls.
module timed_event_queue_core
   import teq_pkg::*;
#(
   parameter int unsigned CAPACITY     = DefCapacity,
   parameter int unsigned HANDLER_BITS = DefHandlerBits,
   localparam int unsigned CntW        = $clog2(CAPACITY + 1)
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [TimeW-1:0]    req_now_time,
   input  logic [HidPortW-1:0] req_handler_id,
   input  logic [ArgW-1:0]     req_handler_arg,
   input  logic [TimeW-1:0]    req_delay_ticks,
   input  logic                req_repeating,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic                rsp_fired,
   output logic [HidPortW-1:0] rsp_fired_handler,
   output logic [ArgW-1:0]     rsp_fired_arg,
   output logic [TimeW-1:0]    rsp_earliest_due,
   output logic [CntW-1:0]     rsp_occupancy
);

   cmd_type  cmd;
   stat_type stat;

   teq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   teq_dpath #(
      .Capacity    (CAPACITY),
      .HandlerBits (HANDLER_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_now_time      (req_now_time),
      .req_handler_id    (req_handler_id),
      .req_handler_arg   (req_handler_arg),
      .req_delay_ticks   (req_delay_ticks),
      .req_repeating     (req_repeating),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_fired         (rsp_fired),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_fired_arg     (rsp_fired_arg),
      .rsp_earliest_due  (rsp_earliest_due),
      .rsp_occupancy     (rsp_occupancy)
   );

endmodule

// File: verif/timed_event_queue_core_test.sv
`timescale 1ns / 1ps

module timed_event_queue_core_test;
   import teq_pkg::*;

   localparam int unsigned Capacity = DefCapacity;

   typedef struct {
      op_type      op;
      logic [31:0] now;
      logic [7:0]  hid;
      logic [15:0] arg;
      logic [31:0] delay;
      logic        rep;
      bit          hold;
   } sched_req_type;

   typedef struct {
      status_type  status;
      logic        fired;
      logic [7:0]  fhid;
      logic [15:0] farg;
      logic [31:0] due;
      logic [5:0]  occ;
   } sched_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = 1'b0;
   logic [31:0] req_now_time = '0;
   logic [7:0]  req_handler_id = '0;
   logic [15:0] req_handler_arg = '0;
   logic [31:0] req_delay_ticks = '0;
   logic        req_repeating = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_fired;
   logic [7:0]  rsp_fired_handler;
   logic [15:0] rsp_fired_arg;
   logic [31:0] rsp_earliest_due;
   logic [5:0]  rsp_occupancy;

   timed_event_queue_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_now_time      (req_now_time),
      .req_handler_id    (req_handler_id),
      .req_handler_arg   (req_handler_arg),
      .req_delay_ticks   (req_delay_ticks),
      .req_repeating     (req_repeating),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_fired         (rsp_fired),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_fired_arg     (rsp_fired_arg),
      .rsp_earliest_due  (rsp_earliest_due),
      .rsp_occupancy     (rsp_occupancy)
   );

   always #1 clock = ~clock;

   sched_req_type queued_requests[$];
   sched_rsp_type predicted_responses[$];
   sched_req_type cur_item;
   sched_rsp_type want;
   int errors = 0;

   logic [31:0] sched_due  [Capacity];
   logic [31:0] sched_intv [Capacity];
   logic [7:0]  sched_hid  [Capacity];
   logic [15:0] sched_arg  [Capacity];
   int unsigned sched_count = 0;

   function automatic void insert_by_due(logic [31:0] d, logic [31:0] iv,
                                         logic [7:0] h, logic [15:0] a);
      int unsigned pos;
      pos = 0;
      while (pos < sched_count && sched_due[pos] <= d)
         pos++;
      for (int unsigned i = sched_count; i > pos; i--) begin
         sched_due[i]  = sched_due[i-1];
         sched_intv[i] = sched_intv[i-1];
         sched_hid[i]  = sched_hid[i-1];
         sched_arg[i]  = sched_arg[i-1];
      end
      sched_due[pos]  = d;
      sched_intv[pos] = iv;
      sched_hid[pos]  = h;
      sched_arg[pos]  = a;
      sched_count++;
   endfunction

   function automatic sched_rsp_type advance_scheduler(sched_req_type r);
      sched_rsp_type res;
      logic [31:0] d;
      logic [31:0] iv;
      res.status = ST_OK;
      res.fired  = 1'b0;
      res.fhid   = '0;
      res.farg   = '0;
      if (r.op == OP_ADD) begin
         if (sched_count >= Capacity)
            res.status = ST_FULL;
         else
            insert_by_due(r.now + r.delay, r.rep ? r.delay : 32'd0, r.hid, r.arg);
      end else if (sched_count > 0 && sched_due[0] <= r.now) begin
         d = sched_due[0];
         iv = sched_intv[0];
         res.fired = 1'b1;
         res.fhid = sched_hid[0];
         res.farg = sched_arg[0];
         for (int unsigned i = 1; i < sched_count; i++) begin
            sched_due[i-1]  = sched_due[i];
            sched_intv[i-1] = sched_intv[i];
            sched_hid[i-1]  = sched_hid[i];
            sched_arg[i-1]  = sched_arg[i];
         end
         sched_count--;
         sched_due[sched_count]  = AllOnes;
         sched_intv[sched_count] = '0;
         if (iv != 0)
            insert_by_due(d + iv, iv, res.fhid, res.farg);
      end else begin
         res.status = ST_NOT_DUE;
      end
      res.due = (sched_count > 0) ? sched_due[0] : AllOnes;
      res.occ = 6'(sched_count);
      return res;
   endfunction

   function automatic sched_req_type make_item(op_type op, logic [31:0] now,
                                               logic [7:0] h, logic [15:0] a,
                                               logic [31:0] delay, logic rep);
      sched_req_type it;
      it.op = op;
      it.now = now;
      it.hid = h;
      it.arg = a;
      it.delay = delay;
      it.rep = rep;
      it.hold = 1'b0;
      return it;
   endfunction

   task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                  act_val);
      end
   endtask

   // sender
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predicted_responses.push_back(advance_scheduler(cur_item));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (queued_requests.size() > 0 &&
                         !(queued_requests[0].hold && predicted_responses.size() > 0)) begin
               cur_item = queued_requests.pop_front();
               req_operation   <= cur_item.op;
               req_now_time    <= cur_item.now;
               req_handler_id  <= cur_item.hid;
               req_handler_arg <= cur_item.arg;
               req_delay_ticks <= cur_item.delay;
               req_repeating   <= cur_item.rep;
               req_valid       <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with two long hold-offs
   int rx_cycle = 0;
   int rx_hold = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else if (rx_cycle == 2000 || rx_cycle == 6000) begin
            rx_hold = 300;
            rsp_ready <= 1'b0;
         end else begin
            case ((rx_cycle / 64) % 6)
               0, 1: rsp_ready <= 1'b1;
               2: rsp_ready <= 1'($urandom_range(0, 1));
               3: rsp_ready <= ($urandom_range(0, 3) == 0);
               4: rsp_ready <= rx_cycle[0];
               default: rsp_ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_responses.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual status %0d due %0h",
                     $time, rsp_status, rsp_earliest_due);
         end else begin
            want = predicted_responses.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_status));
            compare_field("fired", 32'(want.fired), 32'(rsp_fired));
            compare_field("fired_handler", 32'(want.fhid), 32'(rsp_fired_handler));
            compare_field("fired_arg", 32'(want.farg), 32'(rsp_fired_arg));
            compare_field("earliest_due", want.due, rsp_earliest_due);
            compare_field("occupancy", 32'(want.occ), 32'(rsp_occupancy));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      sched_req_type it;
      int unsigned t;
      int rep_slots;
      int phase_kind;
      int phase_len;
      bit is_add;
      bit first;

      for (int i = 0; i < Capacity; i++) begin
         sched_due[i]  = AllOnes;
         sched_intv[i] = '0;
         sched_hid[i]  = '0;
         sched_arg[i]  = '0;
      end

      queued_requests.push_back(make_item(OP_RUN, 32'd0, 8'h00, 16'h0000, 32'd0, 1'b0));
      queued_requests.push_back(make_item(OP_ADD, 32'd0, 8'h00, 16'h0000, 32'd0, 1'b1));
      queued_requests.push_back(make_item(OP_RUN, 32'd0, 8'hFF, 16'hFFFF, '1, 1'b1));
      queued_requests.push_back(make_item(OP_ADD, '1, 8'hFF, 16'hFFFF, '1, 1'b1));
      queued_requests.push_back(make_item(OP_ADD, 32'd10, 8'h55, 16'hAAAA, 32'd5, 1'b0));
      it = make_item(OP_ADD, 32'd10, 8'hAA, 16'h5555, 32'd5, 1'b1);
      it.hold = 1'b1;
      queued_requests.push_back(it);
      queued_requests.push_back(make_item(OP_ADD, 32'd3, 8'h0F, 16'hF0F0, 32'd12, 1'b0));
      queued_requests.push_back(make_item(OP_RUN, 32'd14, 8'h00, 16'h0000, 32'd0, 1'b0));
      queued_requests.push_back(make_item(OP_RUN, 32'd15, 8'h00, 16'h0000, 32'd0, 1'b0));
      queued_requests.push_back(make_item(OP_RUN, 32'd15, 8'h00, 16'h0000, 32'd0, 1'b0));
      queued_requests.push_back(make_item(OP_RUN, 32'd15, 8'h00, 16'h0000, 32'd0, 1'b0));
      queued_requests.push_back(make_item(OP_RUN, 32'd15, 8'h00, 16'h0000, 32'd0, 1'b0));
      queued_requests.push_back(make_item(OP_ADD, 32'd0, 8'h33, 16'h1234, '1, 1'b0));
      queued_requests.push_back(make_item(OP_ADD, 32'hFFFF_FFF0, 8'hC3, 16'h8001, 32'h20,
                                          1'b0));
      queued_requests.push_back(make_item(OP_RUN, 32'd20, 8'h00, 16'h0000, 32'd0, 1'b0));
      queued_requests.push_back(make_item(OP_RUN, '1, 8'h00, 16'h0000, 32'd0, 1'b0));
      queued_requests.push_back(make_item(OP_RUN, '1, 8'h00, 16'h0000, 32'd0, 1'b0));

      // fill, drain and mixed phases; cap long-lived repeating events
      t = 1000;
      rep_slots = 6;
      while (queued_requests.size() < 1317) begin
         phase_kind = $urandom_range(0, 2);
         phase_len = $urandom_range(20, 50);
         first = 1'b1;
         repeat (phase_len) begin
            case (phase_kind)
               0: is_add = ($urandom_range(0, 99) < 85);
               1: is_add = ($urandom_range(0, 99) < 15);
               default: is_add = 1'($urandom_range(0, 1));
            endcase
            t += $urandom_range(0, 12);
            it.op = is_add ? OP_ADD : OP_RUN;
            it.now = t;
            it.hid = 8'($urandom());
            it.arg = 16'($urandom());
            it.rep = 1'($urandom_range(0, 1));
            it.delay = $urandom_range(0, 60);
            if (phase_kind == 2) begin
               if ($urandom_range(0, 3) == 0)
                  it.now = $urandom();
               it.delay = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 200);
            end
            if (is_add && it.rep && it.delay != 0) begin
               if (rep_slots > 0)
                  rep_slots--;
               else
                  it.rep = 1'b0;
            end
            it.hold = first && ($urandom_range(0, 3) == 0);
            first = 1'b0;
            queued_requests.push_back(it);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (queued_requests.size() > 0 || req_valid || predicted_responses.size() > 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
rtl/teq_pkg.sv
rtl/teq_ctrl.sv
rtl/teq_dpath.sv
rtl/timed_event_queue_core.sv
verif/timed_event_queue_core_test.sv
